// File: rtl/core/plist_pkg.sv
// Shared constants, operation and status codes, and interface structs of the
// positional list engine. No dependencies.
`default_nettype none

package plist_pkg;

	localparam int CAPACITY = 32;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int POS_W    = 16;
	localparam int OP_W     = 3;
	localparam int ST_W     = 3;
	localparam int IDX_W    = 6;

	localparam logic [OP_W-1:0] OP_CREATE    = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_END   = 3'd2;
	localparam logic [OP_W-1:0] OP_INS_AT    = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_END   = 3'd5;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd6;
	localparam logic [OP_W-1:0] OP_DISPLAY   = 3'd7;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_LIST = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
	localparam logic [ST_W-1:0] ST_BAD_POS = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic                     valid;
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] element;
		logic [IDX_W-1:0]         index;
		logic                     last;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [AW-1:0]     addr;
		logic [DATA_W-1:0] data;
	} mem_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/plist_ram.sv
// Element store: one write port, one read port with registered read data.
// Depends on plist_pkg.
`default_nettype none

module plist_ram (
	input  wire                               clk,
	input  plist_pkg::mem_wr_t                wr,
	input  wire                               rd_en,
	input  wire [plist_pkg::AW-1:0]           rd_addr,
	output logic [plist_pkg::DATA_W-1:0]      rd_data
);
	import plist_pkg::*;

	logic [DATA_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/plist_ctrl.sv
// Sequencer of the positional list engine: decodes each command, checks it
// against count, and shifts or walks the element store one entry a cycle.
// Depends on plist_pkg.
`default_nettype none

module plist_ctrl (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire [plist_pkg::OP_W-1:0]         op,
	input  wire [plist_pkg::DATA_W-1:0]       value,
	input  wire [plist_pkg::POS_W-1:0]        position,
	output logic                              busy,
	output logic                              rd_en,
	output logic [plist_pkg::AW-1:0]          rd_addr,
	input  wire [plist_pkg::DATA_W-1:0]       rd_data,
	output plist_pkg::mem_wr_t                wr,
	output plist_pkg::result_t                res
);
	import plist_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MOVE  = 3'd1;
	localparam logic [2:0] S_DISP  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_WVAL  = 3'd4;

	logic [2:0]        state_q, state_d;
	logic              created_q, created_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [OP_W-1:0]   op_q, op_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic [AW-1:0]     at_q, at_d;
	logic [AW-1:0]     ptr_q, ptr_d;
	logic [AW-1:0]     end_q, end_d;
	logic              pipe_v_s1, pipe_v_d;
	logic [AW-1:0]     pipe_addr_s1, pipe_addr_d;
	logic              pipe_last_s1, pipe_last_d;

	logic              full, empty, ins_pos_ok, del_pos_ok, op_q_ins;
	logic [AW-1:0]     ins_slot, del_slot, last_slot;

	assign busy  = (state_q != S_IDLE);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	assign ins_pos_ok = (position != '0) &&
		((POS_W+1)'(position) <= (POS_W+1)'(count_q) + (POS_W+1)'(1));
	assign del_pos_ok = (position != '0) &&
		((POS_W+1)'(position) <= (POS_W+1)'(count_q));

	assign last_slot = AW'(count_q - CNT_W'(1));
	assign op_q_ins  = (op_q == OP_INS_FRONT) || (op_q == OP_INS_END) ||
		(op_q == OP_INS_AT);

	always_comb begin
		case (op) inside
			OP_INS_FRONT: ins_slot = '0;
			OP_INS_END:   ins_slot = AW'(count_q);
			default:      ins_slot = AW'(position - POS_W'(1));
		endcase
		case (op) inside
			OP_DEL_FRONT: del_slot = '0;
			OP_DEL_END:   del_slot = last_slot;
			default:      del_slot = AW'(position - POS_W'(1));
		endcase
	end

	always_comb begin
		state_d     = state_q;
		created_d   = created_q;
		count_d     = count_q;
		op_d        = op_q;
		val_d       = val_q;
		at_d        = at_q;
		ptr_d       = ptr_q;
		end_d       = end_q;
		pipe_v_d    = 1'b0;
		pipe_addr_d = pipe_addr_s1;
		pipe_last_d = 1'b0;
		res         = '0;
		wr          = '0;
		rd_en       = 1'b0;
		rd_addr     = ptr_q;

		// read data of the previous cycle: a display word or a shifted entry
		if (pipe_v_s1) begin
			if (op_q == OP_DISPLAY) begin
				res.valid   = 1'b1;
				res.status  = ST_OK;
				res.element = rd_data;
				res.index   = IDX_W'(pipe_addr_s1);
				res.last    = pipe_last_s1;
			end else begin
				wr.en   = 1'b1;
				wr.addr = pipe_addr_s1;
				wr.data = rd_data;
			end
		end

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d       = op;
					val_d      = value;
					res.valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_OK;
					if (op == OP_CREATE) begin
						created_d = 1'b1;
						count_d   = '0;
					end else if (!created_q) begin
						res.status = ST_NO_LIST;
					end else begin
						case (op) inside
							OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
								if (op == OP_INS_AT && !ins_pos_ok) begin
									res.status = ST_BAD_POS;
								end else if (full) begin
									res.status = ST_FULL;
								end else if (ins_slot == AW'(count_q)) begin
									// append: nothing to shift
									wr.en   = 1'b1;
									wr.addr = ins_slot;
									wr.data = value;
									count_d = count_q + CNT_W'(1);
								end else begin
									res.valid = 1'b0;
									ptr_d     = last_slot;
									end_d     = ins_slot;
									at_d      = ins_slot;
									state_d   = S_MOVE;
								end
							end
							OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
								if (empty) begin
									res.status = ST_EMPTY;
								end else if (op == OP_DEL_AT && !del_pos_ok) begin
									res.status = ST_BAD_POS;
								end else if (del_slot == last_slot) begin
									count_d = count_q - CNT_W'(1);
								end else begin
									res.valid = 1'b0;
									ptr_d     = AW'(del_slot + AW'(1));
									end_d     = last_slot;
									state_d   = S_MOVE;
								end
							end
							default: begin
								if (empty) begin
									res.status = ST_EMPTY;
								end else begin
									res.valid = 1'b0;
									ptr_d     = '0;
									end_d     = last_slot;
									state_d   = S_DISP;
								end
							end
						endcase
					end
				end
			end
			S_MOVE: begin
				// insert walks down and moves each entry up; delete the reverse
				rd_en       = 1'b1;
				pipe_v_d    = 1'b1;
				pipe_addr_d = op_q_ins ? AW'(ptr_q + AW'(1)) : AW'(ptr_q - AW'(1));
				if (ptr_q == end_q) begin
					state_d = S_DRAIN;
				end else begin
					ptr_d = op_q_ins ? AW'(ptr_q - AW'(1)) : AW'(ptr_q + AW'(1));
				end
			end
			S_DISP: begin
				rd_en       = 1'b1;
				pipe_v_d    = 1'b1;
				pipe_addr_d = ptr_q;
				pipe_last_d = (ptr_q == end_q);
				if (ptr_q == end_q) begin
					state_d = S_DRAIN;
				end else begin
					ptr_d = AW'(ptr_q + AW'(1));
				end
			end
			S_DRAIN: begin
				if (op_q == OP_DISPLAY) begin
					state_d = S_IDLE;
				end else if (op_q_ins) begin
					state_d = S_WVAL;
				end else begin
					res.valid  = 1'b1;
					res.status = ST_OK;
					res.last   = 1'b1;
					count_d    = count_q - CNT_W'(1);
					state_d    = S_IDLE;
				end
			end
			S_WVAL: begin
				wr.en      = 1'b1;
				wr.addr    = at_q;
				wr.data    = val_q;
				res.valid  = 1'b1;
				res.status = ST_OK;
				res.last   = 1'b1;
				count_d    = count_q + CNT_W'(1);
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			created_q    <= 1'b0;
			count_q      <= '0;
			pipe_v_s1    <= 1'b0;
			pipe_last_s1 <= 1'b0;
		end else begin
			state_q      <= state_d;
			created_q    <= created_d;
			count_q      <= count_d;
			pipe_v_s1    <= pipe_v_d;
			pipe_last_s1 <= pipe_last_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		val_q        <= val_d;
		at_q         <= at_d;
		ptr_q        <= ptr_d;
		end_q        <= end_d;
		pipe_addr_s1 <= pipe_addr_d;
	end

endmodule

`default_nettype wire

// File: rtl/core/positional_list_engine.sv
// Top level of the positional list engine: sequencer, element store and the
// result register. Depends on plist_pkg, plist_ctrl and plist_ram.
`default_nettype none

// A command is taken when start is high and busy is low. Results come out one
// per cycle with strobe high, and the receiver must take each one as it comes.
// Create, append, delete at the end, every rejected command and a display of an
// empty list are answered from idle. An insert walks the entries it moves, then
// drains the last read and writes the new value; a delete walks and drains; a
// display walks its words and drains, the words arriving back to back. This
// comes from the element store, which reads and writes one entry per cycle.
module positional_list_engine (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire [plist_pkg::OP_W-1:0]            op,
	input  wire signed [plist_pkg::DATA_W-1:0]   value,
	input  wire [plist_pkg::POS_W-1:0]           position,
	output logic                                 busy,
	output logic                                 strobe,
	output logic [plist_pkg::ST_W-1:0]           status,
	output logic signed [plist_pkg::DATA_W-1:0]  element,
	output logic [plist_pkg::IDX_W-1:0]          element_index,
	output logic                                 last
);
	import plist_pkg::*;

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;
	mem_wr_t           wr;
	result_t           res;
	logic              strobe_q;
	result_t           res_q;

	plist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (op),
		.value    (value),
		.position (position),
		.busy     (busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr       (wr),
		.res      (res)
	);

	plist_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res;
	end

	assign strobe        = strobe_q;
	assign status        = res_q.status;
	assign element       = res_q.element;
	assign element_index = res_q.index;
	assign last          = res_q.last;

	// a display stream has no gaps
	a_stream_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("display stream broken before its last word");

	// an accepted command either answers at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("accepted command neither answered nor busy");

	// any non-ok answer is a single word
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_OK |-> last)
		else $error("error status without last mark");

	// no command is taken while a display stream is still under way
	a_display_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("command accepted during display stream");

endmodule

`default_nettype wire

// File: bench/positional_list_engine_tb.sv
// Self-checking bench for positional_list_engine: directed edge cases, then random
// list edits with sender gaps, checked word by word against a behavioral list.
// Depends on plist_pkg and the positional_list_engine RTL.
`default_nettype none

module positional_list_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import plist_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_CMDS = 75;

	typedef struct {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] element;
		logic [IDX_W-1:0]         index;
		logic                     last;
	} word_t;

	// Behavioral copy of the list plus the queue of words it still owes.
	class list_book;
		logic signed [DATA_W-1:0] cells [CAPACITY];
		int                       fill;
		bit                       live;
		word_t                    owed [$];
		int                       faults;
		int                       commands;
		int                       words;
		int                       peak;

		function new();
			fill = 0;
			live = 0;
			faults = 0;
			commands = 0;
			words = 0;
			peak = 0;
		endfunction

		function void owe(logic [ST_W-1:0] st, logic signed [DATA_W-1:0] el,
				int idx, bit lst);
			word_t w;
			w.status = st;
			w.element = el;
			w.index = idx[IDX_W-1:0];
			w.last = lst;
			owed.push_back(w);
		endfunction

		function void place(int at, logic signed [DATA_W-1:0] data);
			for (int i = fill; i > at; i--)
				cells[i] = cells[i-1];
			cells[at] = data;
			fill++;
			if (fill > peak)
				peak = fill;
		endfunction

		function void remove(int at);
			for (int i = at; i + 1 < fill; i++)
				cells[i] = cells[i+1];
			fill--;
		endfunction

		function void note_command(logic [OP_W-1:0] cmd, logic signed [DATA_W-1:0] data,
				logic [POS_W-1:0] pos);
			logic [ST_W-1:0] st;
			int p;
			st = ST_OK;
			p = int'(pos);
			commands++;
			if (cmd == OP_CREATE) begin
				fill = 0;
				live = 1;
				owe(ST_OK, '0, 0, 1'b1);
				return;
			end
			if (!live) begin
				owe(ST_NO_LIST, '0, 0, 1'b1);
				return;
			end
			case (cmd)
				OP_INS_FRONT: begin
					if (fill >= CAPACITY) st = ST_FULL;
					else place(0, data);
				end
				OP_INS_END: begin
					if (fill >= CAPACITY) st = ST_FULL;
					else place(fill, data);
				end
				OP_INS_AT: begin
					// position is checked ahead of capacity
					if (p == 0 || p > fill + 1) st = ST_BAD_POS;
					else if (fill >= CAPACITY) st = ST_FULL;
					else place(p - 1, data);
				end
				OP_DEL_FRONT: begin
					if (fill == 0) st = ST_EMPTY;
					else remove(0);
				end
				OP_DEL_END: begin
					if (fill == 0) st = ST_EMPTY;
					else fill--;
				end
				OP_DEL_AT: begin
					// empty wins over a bad position
					if (fill == 0) st = ST_EMPTY;
					else if (p == 0 || p > fill) st = ST_BAD_POS;
					else remove(p - 1);
				end
				default: begin
					if (fill == 0) begin
						st = ST_EMPTY;
					end else begin
						for (int i = 0; i < fill; i++)
							owe(ST_OK, cells[i], i, i == fill - 1);
						return;
					end
				end
			endcase
			owe(st, '0, 0, 1'b1);
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic signed [DATA_W-1:0] el,
				logic [IDX_W-1:0] idx, logic lst);
			word_t want;
			words++;
			if (owed.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected word: status %0d element %0d index %0d last %0b",
						st, el, idx, lst);
				return;
			end
			want = owed.pop_front();
			if (st !== want.status || el !== want.element || idx !== want.index ||
					lst !== want.last) begin
				faults++;
				if (faults <= 10)
					$display({"word mismatch: got st %0d el %0d idx %0d last %0b, ",
						"want st %0d el %0d idx %0d last %0b"},
						st, el, idx, lst, want.status, want.element, want.index,
						want.last);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [OP_W-1:0]          op = OP_CREATE;
	logic signed [DATA_W-1:0] value = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     busy;
	logic                     strobe;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] element;
	logic [IDX_W-1:0]         element_index;
	logic                     last;

	list_book book;
	int       no_idle = 0;
	int       stall_cycles = 0;

	positional_list_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.op            (op),
		.value         (value),
		.position      (position),
		.busy          (busy),
		.strobe        (strobe),
		.status        (status),
		.element       (element),
		.element_index (element_index),
		.last          (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Check result words and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				book.check_result(status, element, element_index, last);
			if ((start && !busy) || strobe)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic issue(input logic [OP_W-1:0] cmd, input logic signed [DATA_W-1:0] data,
			input logic [POS_W-1:0] pos);
		int gap;
		if (no_idle > 0) begin
			gap = 0;
			no_idle--;
		end else begin
			gap = $urandom_range(0, 6);
		end
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		op <= cmd;
		value <= data;
		position <= pos;
		do @(posedge clk); while (busy !== 1'b0);
		book.note_command(cmd, data, pos);
	endtask

	// Hold start low until every owed word has come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (book.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_position(int limit);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return POS_W'($urandom_range(limit + 1, limit + 4));
		if (r == 2) return POS_W'($urandom());
		return POS_W'($urandom_range(1, (limit < 1) ? 1 : limit));
	endfunction

	task automatic random_command();
		int r;
		logic [OP_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		r = $urandom_range(0, 99);
		if (r < 15) cmd = OP_INS_FRONT;
		else if (r < 30) cmd = OP_INS_END;
		else if (r < 48) cmd = OP_INS_AT;
		else if (r < 58) cmd = OP_DEL_FRONT;
		else if (r < 66) cmd = OP_DEL_END;
		else if (r < 82) cmd = OP_DEL_AT;
		else if (r < 97) cmd = OP_DISPLAY;
		else cmd = OP_CREATE;
		// keep lists short so displays stay cheap
		if (book.fill > 12 && r < 48 && $urandom_range(0, 1) == 1)
			cmd = OP_DEL_AT;
		if (cmd == OP_INS_AT) pos = pick_position(book.fill + 1);
		else if (cmd == OP_DEL_AT) pos = pick_position(book.fill);
		else pos = POS_W'($urandom());
		issue(cmd, $urandom(), pos);
	endtask

	// Fill to capacity, then hit the full and bad-position corners.
	task automatic fill_to_capacity();
		int r;
		no_idle = 45;
		while (book.fill < CAPACITY) begin
			r = $urandom_range(0, 2);
			if (r == 0) issue(OP_INS_FRONT, $urandom(), '0);
			else if (r == 1) issue(OP_INS_END, $urandom(), '0);
			else issue(OP_INS_AT, $urandom(), POS_W'($urandom_range(1, book.fill + 1)));
		end
		issue(OP_INS_FRONT, $urandom(), '0);
		issue(OP_INS_END, $urandom(), '0);
		issue(OP_INS_AT, $urandom(), POS_W'(CAPACITY + 1));
		issue(OP_INS_AT, $urandom(), POS_W'(CAPACITY + 2));
		issue(OP_DISPLAY, '0, '0);
		issue(OP_DEL_AT, '0, POS_W'(CAPACITY + 1));
		issue(OP_DEL_AT, '0, POS_W'(CAPACITY));
		issue(OP_DEL_AT, '0, 16'd1);
	endtask

	initial begin
		book = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: nothing exists before create
		issue(OP_DISPLAY, '0, '0);
		issue(OP_INS_FRONT, 32'sd5, '0);
		issue(OP_DEL_AT, '0, 16'd1);
		issue(OP_CREATE, '0, '0);
		// empty list corners
		issue(OP_DISPLAY, '0, '0);
		issue(OP_DEL_FRONT, '0, '0);
		issue(OP_DEL_END, '0, '0);
		issue(OP_DEL_AT, '0, 16'd0);
		issue(OP_INS_AT, 32'sd1, 16'd0);
		issue(OP_INS_AT, 32'sd1, 16'd2);
		// value extremes and edge positions
		issue(OP_INS_AT, 32'h8000_0000, 16'd1);
		issue(OP_INS_FRONT, 32'h7FFF_FFFF, '0);
		issue(OP_INS_END, -32'sd1, 16'hFFFF);
		issue(OP_INS_AT, 32'sd0, 16'd4);
		issue(OP_INS_AT, 32'h5A5A_A5A5, 16'hFFFF);
		issue(OP_DEL_AT, '0, 16'd0);
		issue(OP_DEL_AT, '0, 16'd5);
		issue(OP_DEL_AT, '0, 16'hFFFF);
		issue(OP_DISPLAY, '0, '0);
		issue(OP_DEL_AT, '0, 16'd2);
		issue(OP_DEL_FRONT, '0, '0);
		issue(OP_DEL_END, '0, '0);
		issue(OP_DISPLAY, '0, '0);
		issue(OP_CREATE, '0, '0);
		issue(OP_DISPLAY, '0, '0);

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 25 == 10)
				no_idle = 12;
			if (n == 30)
				fill_to_capacity();
			if (n == 55)
				drain();
			random_command();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d commands, checked %0d result words; list grew to %0d of %0d entries.",
			book.commands, book.words, book.peak, CAPACITY);
		if (book.faults == 0 && book.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d faults, %0d words never arrived", book.faults, book.pending());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
